### rtl/core/kmsf_pkg.sv
// Shared types and constants for the k-way merge sample-count filter.
// No dependencies; kmsf_cell and the top level in rtl/core refer to it by scoped name.
`default_nettype none

package kmsf_pkg;

  localparam int LANE_W      = 4;
  localparam int KEY_FIELD_W = 62;
  localparam int COUNT_W     = 32;
  localparam int CFG_W       = 5;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_MERGE = 1'b1;

  localparam logic [CFG_W-1:0] MIN_SAMPLES_RESET = 5'd1;

  typedef struct packed {
    logic                   cmd;
    logic [LANE_W-1:0]      lane;
    logic [KEY_FIELD_W-1:0] record_key;
    logic [COUNT_W-1:0]     record_count;
    logic                   record_valid;
  } item_t;

  typedef struct packed {
    logic [LANE_W-1:0]      out_lane;
    logic [KEY_FIELD_W-1:0] out_key;
    logic [COUNT_W-1:0]     out_count;
    logic                   consumed;
    logic                   kept;
    logic                   done_res;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic load_valid;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/kmsf_cell.sv
// One lane cell of the head-record ring: holds key, count and live flag.
// Loads from the item bus or takes its neighbor's record on a shift.
// Depends on kmsf_pkg.
`default_nettype none

module kmsf_cell #(
  parameter int KEY_W = 62
) (
  input  wire                           clk,
  input  wire                           rst,
  input  kmsf_pkg::cell_ctrl_t          ctrl,
  input  wire [KEY_W-1:0]               load_key,
  input  wire [kmsf_pkg::COUNT_W-1:0]   load_count,
  input  wire                           nb_alive,
  input  wire [KEY_W-1:0]               nb_key,
  input  wire [kmsf_pkg::COUNT_W-1:0]   nb_count,
  output logic                          alive,
  output logic [KEY_W-1:0]              key,
  output logic [kmsf_pkg::COUNT_W-1:0]  count
);

  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else if (ctrl.load) begin
      alive <= ctrl.load_valid;
    end else if (ctrl.shift) begin
      alive <= nb_alive;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && ctrl.load_valid) begin
      key   <= load_key;
      count <= load_count;
    end else if (ctrl.shift) begin
      key   <= nb_key;
      count <= nb_count;
    end
  end

endmodule

`default_nettype wire

### rtl/core/kmsf_minscan.sv
// Running minimum and match counter fed one head record per cycle while
// en is high, from the end of the cell ring. Does not use kmsf_pkg itself.
`default_nettype none

module kmsf_minscan #(
  parameter int KEY_W = 62,
  parameter int CNT_W = 5
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              clr,
  input  wire              en,
  input  wire              alive,
  input  wire [KEY_W-1:0]  key,
  output logic             found,
  output logic [KEY_W-1:0] min_key,
  output logic [CNT_W-1:0] match_cnt
);

  logic take_new;

  assign take_new = alive && (!found || key < min_key);

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      found     <= 1'b0;
      match_cnt <= '0;
    end else if (en && take_new) begin
      found     <= 1'b1;
      match_cnt <= CNT_W'(1);
    end else if (en && alive && key == min_key) begin
      match_cnt <= match_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en && take_new) begin
      min_key <= key;
    end
  end

endmodule

`default_nettype wire

### rtl/core/kway_merge_sample_count_filter.sv
// Top level of the k-way merge sample-count filter: cell ring, scanner, sequencer.
// Depends on kmsf_pkg, kmsf_cell and kmsf_minscan.
//
// A load (cmd 0) writes one lane's head record, or clears the lane when
// record_valid is low; busy stays low. A merge (cmd 1) keeps busy high while
// the ring of head cells rotates once through the minimum scanner, then once
// more past the result register, giving one result per cycle, lane 0 first,
// with last on lane NUM_LANES-1. With no live lane a merge skips the second
// rotation and gives a single done result. Results are shown for one cycle on
// result_strobe; the receiver cannot stall, so it must take every transfer.
// The next command may start in the cycle the last result is shown.
`default_nettype none

module kway_merge_sample_count_filter #(
  parameter int NUM_LANES = 16,
  parameter int KMER_LEN  = 31
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  kmsf_pkg::item_t              item,
  output logic                         result_strobe,
  output kmsf_pkg::result_t            result,
  input  wire                          cfg_we,
  input  wire [kmsf_pkg::CFG_W-1:0]    cfg_data
);

  localparam int KEY_W  = (2 * KMER_LEN > kmsf_pkg::KEY_FIELD_W) ?
                          kmsf_pkg::KEY_FIELD_W : 2 * KMER_LEN;
  localparam int STEP_W = $clog2(NUM_LANES);
  localparam int CNT_W  = $clog2(NUM_LANES + 1);
  localparam int CMP_W  = (CNT_W > kmsf_pkg::CFG_W) ? CNT_W : kmsf_pkg::CFG_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_LANES - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  state_t                          state;
  logic [STEP_W-1:0]               step;
  logic [kmsf_pkg::CFG_W-1:0]      min_samples;

  logic                            accept;
  logic                            merge_go;
  logic                            load_go;
  logic                            shift;
  logic                            emitting;
  logic                            hit;
  logic                            kept;

  logic                            cell_alive [NUM_LANES];
  logic [KEY_W-1:0]                cell_key   [NUM_LANES];
  logic [kmsf_pkg::COUNT_W-1:0]    cell_count [NUM_LANES];

  logic                            scan_found;
  logic [KEY_W-1:0]                scan_min;
  logic [CNT_W-1:0]                scan_match_cnt;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign merge_go = accept && (item.cmd == kmsf_pkg::CMD_MERGE);
  assign load_go  = accept && (item.cmd == kmsf_pkg::CMD_LOAD);
  assign emitting = (state == S_EMIT) && scan_found;
  assign shift    = (state == S_SCAN) || emitting;
  assign hit      = cell_alive[0] && (cell_key[0] == scan_min);
  assign kept     = CMP_W'(scan_match_cnt) >= CMP_W'(min_samples);

  genvar gi;
  generate
    for (gi = 0; gi < NUM_LANES; gi++) begin : g_cell
      kmsf_pkg::cell_ctrl_t ctrl;
      logic                          nb_alive;
      logic [KEY_W-1:0]              nb_key;
      logic [kmsf_pkg::COUNT_W-1:0]  nb_count;

      assign ctrl.shift      = shift;
      assign ctrl.load       = load_go && (32'(item.lane) == gi);
      assign ctrl.load_valid = item.record_valid;

      if (gi == NUM_LANES - 1) begin : g_wrap
        assign nb_alive = cell_alive[0] && !(emitting && hit);
        assign nb_key   = cell_key[0];
        assign nb_count = cell_count[0];
      end else begin : g_next
        assign nb_alive = cell_alive[gi+1];
        assign nb_key   = cell_key[gi+1];
        assign nb_count = cell_count[gi+1];
      end

      kmsf_cell #(.KEY_W(KEY_W)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .load_key   (item.record_key[KEY_W-1:0]),
        .load_count (item.record_count),
        .nb_alive   (nb_alive),
        .nb_key     (nb_key),
        .nb_count   (nb_count),
        .alive      (cell_alive[gi]),
        .key        (cell_key[gi]),
        .count      (cell_count[gi])
      );
    end
  endgenerate

  kmsf_minscan #(.KEY_W(KEY_W), .CNT_W(CNT_W)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .clr       (merge_go),
    .en        (state == S_SCAN),
    .alive     (cell_alive[0]),
    .key       (cell_key[0]),
    .found     (scan_found),
    .min_key   (scan_min),
    .match_cnt (scan_match_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples <= kmsf_pkg::MIN_SAMPLES_RESET;
    end else if (cfg_we) begin
      min_samples <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (merge_go) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) begin
            step  <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          result_strobe <= 1'b1;
          step          <= step + STEP_W'(1);
          if (!scan_found || step == LAST_STEP) begin
            step  <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      if (!scan_found) begin
        result.out_lane  <= '0;
        result.out_key   <= '0;
        result.out_count <= '0;
        result.consumed  <= 1'b0;
        result.kept      <= 1'b0;
        result.done_res  <= 1'b1;
        result.last      <= 1'b1;
      end else begin
        result.out_lane  <= kmsf_pkg::LANE_W'(step);
        result.out_key   <= kmsf_pkg::KEY_FIELD_W'(scan_min);
        result.out_count <= (hit && kept) ? cell_count[0] : '0;
        result.consumed  <= hit;
        result.kept      <= kept;
        result.done_res  <= 1'b0;
        result.last      <= (step == LAST_STEP);
      end
    end
  end

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.done_res |-> result.last)
    else $error("done transfer without last");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last |-> !busy)
    else $error("busy still high with last transfer");

  a_merge_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.cmd == kmsf_pkg::CMD_MERGE |=> busy)
    else $error("merge accepted without going busy");

  a_count_needs_hit: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.out_count != '0 |-> result.kept && result.consumed)
    else $error("nonzero count on a lane not consumed or not kept");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.cmd == kmsf_pkg::CMD_LOAD |=> !result_strobe)
    else $error("load produced a transfer");
`endif

endmodule

`default_nettype wire

### dv/kway_merge_sample_count_filter_tb.sv
// Self-checking testbench for kway_merge_sample_count_filter: a directed table, then
// random phases of load/merge commands, checked against an in-bench merge predictor.
// Depends on kmsf_pkg and the kway_merge_sample_count_filter RTL.
`timescale 1ns / 1ps

module kway_merge_sample_count_filter_tb;

  localparam int NUM_LANES = 16;
  localparam int KMER_LEN  = 31;
  localparam logic [kmsf_pkg::KEY_FIELD_W-1:0] KEY_MASK =
    {kmsf_pkg::KEY_FIELD_W{1'b1}} >> (62 - 2*KMER_LEN);
  localparam kmsf_pkg::result_t DONE_RESULT = '{out_lane: '0, out_key: '0, out_count: '0,
                                                consumed: 1'b0, kept: 1'b0, done_res: 1'b1,
                                                last: 1'b1};
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 40;
  localparam int MAX_REPORT = 10;

  typedef enum logic [1:0] {ROW_LOAD, ROW_MERGE, ROW_MERGE_DONE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [kmsf_pkg::LANE_W-1:0]      lane;
    logic [kmsf_pkg::KEY_FIELD_W-1:0] key;
    logic [kmsf_pkg::COUNT_W-1:0]     count;
    logic                             valid;
    logic [kmsf_pkg::CFG_W-1:0]       cfg;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  kmsf_pkg::item_t item = '0;
  logic result_strobe;
  kmsf_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [kmsf_pkg::CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic [kmsf_pkg::KEY_FIELD_W-1:0] lane_key [NUM_LANES];
  logic [kmsf_pkg::COUNT_W-1:0]     lane_count [NUM_LANES];
  logic                             lane_alive [NUM_LANES];
  logic [kmsf_pkg::CFG_W-1:0]       keep_threshold = kmsf_pkg::MIN_SAMPLES_RESET;

  kmsf_pkg::result_t owed_results [$];
  kmsf_pkg::result_t oldest_owed;
  int fail_count = 0;

  // random phase shape
  logic [kmsf_pkg::KEY_FIELD_W-1:0] pool_base;
  int pool_span;
  int refill_pct;
  bit steady;

  kway_merge_sample_count_filter #(
    .NUM_LANES(NUM_LANES),
    .KMER_LEN (KMER_LEN)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_strobe(result_strobe),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void owe_result(kmsf_pkg::result_t r);
    owed_results = {owed_results, r};
  endfunction

  task automatic merge_or_load(kmsf_pkg::item_t it);
    logic [kmsf_pkg::KEY_FIELD_W-1:0] low_key;
    bit found;
    int hits;
    bit keep;
    bit hit;
    kmsf_pkg::result_t r;
    found = 1'b0;
    low_key = '0;
    hits = 0;
    if (it.cmd == kmsf_pkg::CMD_LOAD) begin
      if (it.record_valid) begin
        lane_key[it.lane]   = it.record_key & KEY_MASK;
        lane_count[it.lane] = it.record_count;
        lane_alive[it.lane] = 1'b1;
      end else begin
        lane_alive[it.lane] = 1'b0;
      end
    end else begin
      for (int i = 0; i < NUM_LANES; i++) begin
        if (lane_alive[i]) begin
          if (!found || lane_key[i] < low_key) begin
            low_key = lane_key[i];
            found = 1'b1;
            hits = 0;
          end
          if (lane_key[i] == low_key) hits++;
        end
      end
      if (!found) begin
        owe_result(DONE_RESULT);
      end else begin
        keep = (hits >= keep_threshold);
        for (int i = 0; i < NUM_LANES; i++) begin
          hit = lane_alive[i] && (lane_key[i] == low_key);
          r.out_lane  = kmsf_pkg::LANE_W'(i);
          r.out_key   = low_key;
          r.out_count = (hit && keep) ? lane_count[i] : '0;
          r.consumed  = hit;
          r.kept      = keep;
          r.done_res  = 1'b0;
          r.last      = (i == NUM_LANES - 1);
          owe_result(r);
          if (hit) lane_alive[i] = 1'b0;
        end
      end
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(kmsf_pkg::item_t it, bit typed, kmsf_pkg::result_t want);
    int gap;
    int n0;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    n0 = owed_results.size();
    merge_or_load(it);
    if (typed) begin
      while (owed_results.size() > n0) void'(owed_results.pop_back());
      owe_result(want);
    end
    @(negedge clk);
  endtask

  // Hold off until the block is idle; loads leave nothing owed, so add margin.
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (owed_results.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_threshold(logic [kmsf_pkg::CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    keep_threshold = v;
  endtask

  function automatic row_t mk_row(row_kind_t kind, int lane,
                                  logic [kmsf_pkg::KEY_FIELD_W-1:0] key,
                                  logic [kmsf_pkg::COUNT_W-1:0] count, bit valid, int cfg);
    row_t r;
    r.kind  = kind;
    r.lane  = kmsf_pkg::LANE_W'(lane);
    r.key   = key;
    r.count = count;
    r.valid = valid;
    r.cfg   = kmsf_pkg::CFG_W'(cfg);
    return r;
  endfunction

  function automatic kmsf_pkg::item_t draw_item();
    kmsf_pkg::item_t it;
    int dead [$];
    int pick;
    it.cmd          = kmsf_pkg::CMD_LOAD;
    it.lane         = kmsf_pkg::LANE_W'($urandom_range(0, NUM_LANES - 1));
    it.record_key   = pool_base + kmsf_pkg::KEY_FIELD_W'($urandom_range(0, pool_span));
    it.record_count = $urandom;
    it.record_valid = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) if (!lane_alive[i]) dead = {dead, i};
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.record_key   = kmsf_pkg::KEY_FIELD_W'({$urandom, $urandom});
      it.record_valid = 1'($urandom_range(0, 1));
    end else if (pick < 13) begin
      it.record_valid = 1'b0;
    end else if (dead.size() != 0 && $urandom_range(0, 99) < refill_pct) begin
      it.lane = kmsf_pkg::LANE_W'(dead[$urandom_range(0, dead.size() - 1)]);
    end else begin
      it.cmd = kmsf_pkg::CMD_MERGE;
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORT)
          $display("%0t: result with nothing owed: lane %0d key %h count %h flags %b%b%b%b",
                   $realtime, result.out_lane, result.out_key, result.out_count,
                   result.consumed, result.kept, result.done_res, result.last);
      end else begin
        oldest_owed = owed_results.pop_front();
        if (result.out_lane !== oldest_owed.out_lane ||
            result.out_key !== oldest_owed.out_key ||
            result.out_count !== oldest_owed.out_count ||
            result.consumed !== oldest_owed.consumed ||
            result.kept !== oldest_owed.kept ||
            result.done_res !== oldest_owed.done_res ||
            result.last !== oldest_owed.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORT) begin
            $display("%0t: mismatch exp lane %0d key %h count %h c/k/d/l %b%b%b%b",
                     $realtime, oldest_owed.out_lane, oldest_owed.out_key,
                     oldest_owed.out_count, oldest_owed.consumed, oldest_owed.kept,
                     oldest_owed.done_res, oldest_owed.last);
            $display("               got lane %0d key %h count %h c/k/d/l %b%b%b%b",
                     result.out_lane, result.out_key, result.out_count,
                     result.consumed, result.kept, result.done_res, result.last);
          end
        end
      end
    end
  end

  initial begin
    row_t plan [$];
    kmsf_pkg::item_t it;
    logic [kmsf_pkg::CFG_W-1:0] thr;
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_key[i]   = '0;
      lane_count[i] = '0;
      lane_alive[i] = 1'b0;
    end
    steady = 1'b0;

    plan = {plan, mk_row(ROW_MERGE_DONE, 0, '0, '0, 0, 0)};
    plan = {plan, mk_row(ROW_LOAD, 0, '1, '1, 1, 0)};
    plan = {plan, mk_row(ROW_LOAD, 15, '0, '1, 1, 0)};
    plan = {plan, mk_row(ROW_LOAD, 7, '0, '0, 1, 0)};
    plan = {plan, mk_row(ROW_MERGE, 0, '0, '0, 0, 0)};
    plan = {plan, mk_row(ROW_MERGE, 0, '0, '0, 0, 0)};
    plan = {plan, mk_row(ROW_MERGE_DONE, 0, '0, '0, 0, 0)};
    plan = {plan, mk_row(ROW_CFG, 0, '0, '0, 0, 0)};
    plan = {plan, mk_row(ROW_LOAD, 3, 62'd5, 32'd9, 1, 0)};
    plan = {plan, mk_row(ROW_LOAD, 3, '1, '1, 0, 0)};
    plan = {plan, mk_row(ROW_MERGE_DONE, 0, '0, '0, 0, 0)};
    plan = {plan, mk_row(ROW_LOAD, 4, 62'd9, 32'd2, 1, 0)};
    plan = {plan, mk_row(ROW_LOAD, 5, 62'd9, 32'd3, 1, 0)};
    plan = {plan, mk_row(ROW_MERGE, 0, '0, '0, 0, 0)};
    plan = {plan, mk_row(ROW_CFG, 0, '0, '0, 0, 31)};
    plan = {plan, mk_row(ROW_LOAD, 1, 62'd1, 32'd7, 1, 0)};
    plan = {plan, mk_row(ROW_LOAD, 2, 62'd1, 32'd8, 1, 0)};
    plan = {plan, mk_row(ROW_MERGE, 0, '0, '0, 0, 0)};
    plan = {plan, mk_row(ROW_CFG, 0, '0, '0, 0, 2)};
    plan = {plan, mk_row(ROW_LOAD, 8, 62'd3, 32'd4, 1, 0)};
    plan = {plan, mk_row(ROW_LOAD, 9, 62'd3, 32'd5, 1, 0)};
    plan = {plan, mk_row(ROW_LOAD, 10, 62'd2, 32'd6, 1, 0)};
    plan = {plan, mk_row(ROW_MERGE, 0, '0, '0, 0, 0)};
    plan = {plan, mk_row(ROW_MERGE, 0, '0, '0, 0, 0)};
    plan = {plan, mk_row(ROW_MERGE_DONE, 0, '0, '0, 0, 0)};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_threshold(plan[i].cfg);
      end else begin
        it.cmd          = (plan[i].kind == ROW_LOAD) ? kmsf_pkg::CMD_LOAD
                                                     : kmsf_pkg::CMD_MERGE;
        it.lane         = plan[i].lane;
        it.record_key   = plan[i].key;
        it.record_count = plan[i].count;
        it.record_valid = plan[i].valid;
        send_item(it, plan[i].kind == ROW_MERGE_DONE, DONE_RESULT);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: thr = kmsf_pkg::CFG_W'(NUM_LANES);
        1: thr = '0;
        2: thr = '1;
        default: begin
          case ($urandom_range(0, 5))
            0: thr = '0;
            1: thr = 5'd1;
            2: thr = kmsf_pkg::CFG_W'(NUM_LANES);
            3: thr = kmsf_pkg::CFG_W'($urandom_range(2, 15));
            4: thr = kmsf_pkg::CFG_W'($urandom_range(17, 31));
            default: thr = kmsf_pkg::CFG_W'($urandom_range(1, 4));
          endcase
        end
      endcase
      write_threshold(thr);
      case ($urandom_range(0, 3))
        0: pool_base = kmsf_pkg::KEY_FIELD_W'($urandom_range(0, 8));
        1: pool_base = '1 - kmsf_pkg::KEY_FIELD_W'(8);
        default: pool_base = kmsf_pkg::KEY_FIELD_W'({$urandom, $urandom});
      endcase
      pool_span  = (ph == 0) ? 0 : $urandom_range(0, 3);
      refill_pct = (ph == 0) ? 100 : ((ph % 4 == 3) ? 20 : (($urandom_range(0, 1)) ? 100 : 60));
      steady     = (ph % 3 == 1);
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_item(draw_item(), 1'b0, DONE_RESULT);
      end
    end

    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4 * NUM_LANES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
